/* src/max_frequency_stack_assert.svh */
// Assertion macros for the maximum-frequency stack.
// Needs a clock and a reset signal in the scope where a macro is used.
`ifndef MAX_FREQUENCY_STACK_ASSERT_SVH
`define MAX_FREQUENCY_STACK_ASSERT_SVH

// condition holds at every edge outside reset
`define MFS_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MFS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* src/mfs_pkg.sv */
// Shared types and constants of the maximum-frequency stack.
// No dependencies.
package mfs_pkg;
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   typedef enum logic {
      FUNC_PUSH = 1'b0,
      FUNC_POP  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_PUSHED  = 2'd0,
      ST_POPPED  = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_PUSH_A,
      S_PUSH_B,
      S_POP_A,
      S_POP_B,
      S_POP_C
   } state_type;

   typedef struct packed {
      logic compare;
      logic bump;
      logic claim;
      logic drop;
   } cell_cmd_type;

   typedef struct packed {
      logic             hit;
      logic             free;
      logic [CNT_W-1:0] count;
   } chain_type;
endpackage

/* src/mfs_if.sv */
// Handshake channels of the maximum-frequency stack.
// Depends on mfs_pkg.
interface mfs_req_if import mfs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [DATA_W-1:0] push_value;
   modport source (output valid, func, push_value, input ready);
   modport sink   (input valid, func, push_value, output ready);
endinterface

interface mfs_rsp_if import mfs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] popped_value;
   logic [1:0]        status;
   modport source (output valid, popped_value, status, input ready);
   modport sink   (input valid, popped_value, status, output ready);
endinterface

/* src/mfs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* src/mfs_cell.sv */
// One entry of the value count table: tag, count and a registered match flag.
// Depends on mfs_pkg; cells are chained so the lowest-indexed hit or free entry wins.
module mfs_cell import mfs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cell_cmd_type      cmd,
   input  logic [DATA_W-1:0] key,
   input  chain_type         chain_in,
   output chain_type         chain_out
);
   logic [DATA_W-1:0] tag_ff, tag_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              match_ff, match_in;
   logic              first_hit, first_free;

   assign first_hit  = match_ff && !chain_in.hit;
   assign first_free = (count_ff == '0) && !chain_in.free;

   always_comb begin
      tag_in   = tag_ff;
      count_in = count_ff;
      match_in = match_ff;
      if (cmd.compare) begin
         match_in = (count_ff != '0) && (tag_ff == key);
      end
      if (cmd.bump && first_hit) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.claim && first_free) begin
         tag_in   = key;
         count_in = CNT_W'(1);
      end
      if (cmd.drop && first_hit) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         match_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         match_ff <= match_in;
      end
      tag_ff <= tag_in;
   end

   assign chain_out.hit   = chain_in.hit || match_ff;
   assign chain_out.free  = chain_in.free || (count_ff == '0);
   assign chain_out.count = first_hit ? count_ff : chain_in.count;
endmodule

/* src/max_frequency_stack.sv */
// Maximum-frequency stack. A push runs S_LOOKUP, S_PUSH_A, S_PUSH_B and a pop
// S_LOOKUP, S_POP_A to S_POP_C (an empty pop ends in S_LOOKUP, a refused push in
// S_PUSH_A) until its result is registered; the block takes one item at a time. This
// is set by the count cells, whose match flags are registered after the key is
// broadcast, and the registered reads of level-top, free-slot and item memories. The
// output register lets the next item enter while a result waits. No clearing pass.
module max_frequency_stack import mfs_pkg::*; (
   input logic   clock,
   input logic   reset,
   mfs_req_if.sink   req_chan,
   mfs_rsp_if.source rsp_chan
);
`include "max_frequency_stack_assert.svh"

   state_type state_ff, state_in;

   logic              func_ff;
   logic [DATA_W-1:0] value_ff;
   logic [CNT_W-1:0]  free_count_ff, free_count_in;
   logic [CNT_W-1:0]  top_level_ff, top_level_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [IDX_W-1:0]  lvl_idx_ff, lvl_idx_in;
   logic [IDX_W-1:0]  fs_idx_ff;
   logic [CAPACITY-1:0] lt_valid_ff, fs_valid_ff;
   logic              lt_vld_ff, fs_vld_ff;

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   status_type        rsp_status_ff;

   // memory ports
   logic              lt_we;
   logic [IDX_W-1:0]  lt_waddr, lt_raddr;
   logic [CNT_W-1:0]  lt_wdata, lt_rdata, lt_word;
   logic              fs_we;
   logic [IDX_W-1:0]  fs_waddr, fs_raddr;
   logic [IDX_W-1:0]  fs_rdata, fs_word;
   logic              it_we;
   logic [DATA_W-1:0] iv_rdata;
   logic [IDX_W-1:0]  ib_wdata, ib_rdata, it_raddr;

   // count table
   cell_cmd_type      cmd;
   logic [DATA_W-1:0] key;
   chain_type         chain [CAPACITY+1];

   logic              out_free, finish, accept;
   status_type        fin_status;
   logic [DATA_W-1:0] fin_value;
   logic              refuse;

   assign accept    = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign lt_word   = lt_vld_ff ? lt_rdata : '0;
   assign fs_word   = fs_vld_ff ? fs_rdata : fs_idx_ff;
   assign refuse    = (free_count_ff == '0) ||
                      (!chain[CAPACITY].hit && !chain[CAPACITY].free) ||
                      (chain[CAPACITY].hit && chain[CAPACITY].count >= CNT_W'(CAPACITY));
   assign key       = (state_ff == S_POP_B) ? iv_rdata : value_ff;

   assign chain[0] = '{hit: 1'b0, free: 1'b0, count: '0};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      mfs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .key       (key),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1])
      );
   end

   mfs_ram #(.WIDTH(CNT_W), .DEPTH(CAPACITY)) u_level_top (
      .clock (clock), .we (lt_we), .waddr (lt_waddr), .wdata (lt_wdata),
      .raddr (lt_raddr), .rdata (lt_rdata)
   );
   mfs_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free_slots (
      .clock (clock), .we (fs_we), .waddr (fs_waddr), .wdata (slot_ff),
      .raddr (fs_raddr), .rdata (fs_rdata)
   );
   mfs_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_item_value (
      .clock (clock), .we (it_we), .waddr (slot_ff), .wdata (value_ff),
      .raddr (it_raddr), .rdata (iv_rdata)
   );
   mfs_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_item_below (
      .clock (clock), .we (it_we), .waddr (slot_ff), .wdata (ib_wdata),
      .raddr (it_raddr), .rdata (ib_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_LOOKUP;
         S_LOOKUP: begin
            if (func_ff == FUNC_PUSH) begin
               state_in = S_PUSH_A;
            end else if (top_level_ff != '0) begin
               state_in = S_POP_A;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_PUSH_A: begin
            if (!refuse) begin
               state_in = S_PUSH_B;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_PUSH_B: if (out_free) state_in = S_IDLE;
         S_POP_A: begin
            if (lt_word != '0) begin
               state_in = S_POP_B;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_POP_B:  state_in = S_POP_C;
         S_POP_C:  if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_chan.ready = (state_ff == S_IDLE);
      cmd           = '0;
      finish        = 1'b0;
      fin_status    = ST_PUSHED;
      fin_value     = '0;
      lt_we         = 1'b0;
      lt_waddr      = '0;
      lt_wdata      = '0;
      lt_raddr      = '0;
      fs_we         = 1'b0;
      fs_waddr      = free_count_ff[IDX_W-1:0];
      fs_raddr      = '0;
      it_we         = 1'b0;
      it_raddr      = slot_ff;
      ib_wdata      = slot_ff;
      free_count_in = free_count_ff;
      top_level_in  = top_level_ff;
      slot_in       = slot_ff;
      lvl_idx_in    = lvl_idx_ff;
      unique case (state_ff)
         S_IDLE: ;
         S_LOOKUP: begin
            cmd.compare = (func_ff == FUNC_PUSH);
            fs_raddr    = IDX_W'(free_count_ff - CNT_W'(1));
            lt_raddr    = IDX_W'(top_level_ff - CNT_W'(1));
            if (func_ff == FUNC_POP && top_level_ff == '0) begin
               finish     = out_free;
               fin_status = ST_EMPTY;
            end
         end
         S_PUSH_A: begin
            lt_raddr = chain[CAPACITY].count[IDX_W-1:0];
            if (refuse) begin
               finish     = out_free;
               fin_status = ST_FULL;
            end else begin
               cmd.bump      = chain[CAPACITY].hit;
               cmd.claim     = !chain[CAPACITY].hit;
               lvl_idx_in    = chain[CAPACITY].count[IDX_W-1:0];
               slot_in       = fs_word;
               free_count_in = free_count_ff - CNT_W'(1);
            end
         end
         S_PUSH_B: begin
            // keep reading the same level while the result waits
            lt_raddr   = lvl_idx_ff;
            finish     = out_free;
            fin_status = ST_PUSHED;
            ib_wdata   = (lt_word == '0) ? slot_ff : IDX_W'(lt_word - CNT_W'(1));
            it_we      = out_free;
            lt_we      = out_free;
            lt_waddr   = lvl_idx_ff;
            lt_wdata   = CNT_W'(slot_ff) + CNT_W'(1);
            if (out_free && CNT_W'(lvl_idx_ff) + CNT_W'(1) > top_level_ff) begin
               top_level_in = CNT_W'(lvl_idx_ff) + CNT_W'(1);
            end
         end
         S_POP_A: begin
            lt_raddr = IDX_W'(top_level_ff - CNT_W'(1));
            slot_in  = IDX_W'(lt_word - CNT_W'(1));
            it_raddr = IDX_W'(lt_word - CNT_W'(1));
            if (lt_word == '0) begin
               finish     = out_free;
               fin_status = ST_EMPTY;
            end
         end
         S_POP_B: begin
            cmd.compare = 1'b1;
            lt_we       = 1'b1;
            lt_waddr    = IDX_W'(top_level_ff - CNT_W'(1));
            // drop the level when its stack runs out
            if (ib_rdata == slot_ff) begin
               lt_wdata     = '0;
               top_level_in = top_level_ff - CNT_W'(1);
            end else begin
               lt_wdata = CNT_W'(ib_rdata) + CNT_W'(1);
            end
            if (free_count_ff < CNT_W'(CAPACITY)) begin
               fs_we         = 1'b1;
               free_count_in = free_count_ff + CNT_W'(1);
            end
         end
         S_POP_C: begin
            finish     = out_free;
            fin_status = ST_POPPED;
            fin_value  = value_ff;
            cmd.drop   = out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_count_ff <= CNT_W'(CAPACITY);
         top_level_ff  <= '0;
         lt_valid_ff   <= '0;
         fs_valid_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_count_ff <= free_count_in;
         top_level_ff  <= top_level_in;
         if (lt_we) lt_valid_ff[lt_waddr] <= 1'b1;
         if (fs_we) fs_valid_ff[fs_waddr] <= 1'b1;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      lt_vld_ff <= lt_valid_ff[lt_raddr];
      fs_vld_ff <= fs_valid_ff[fs_raddr];
      fs_idx_ff <= fs_raddr;
      slot_ff    <= slot_in;
      lvl_idx_ff <= lvl_idx_in;
      if (accept) begin
         func_ff  <= req_chan.func;
         value_ff <= req_chan.push_value;
      end else if (state_ff == S_POP_B) begin
         // hold the popped value for the count update and the result
         value_ff <= iv_rdata;
      end
      if (finish) begin
         rsp_value_ff  <= fin_value;
         rsp_status_ff <= fin_status;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.popped_value = rsp_value_ff;
   assign rsp_chan.status       = rsp_status_ff;

   `MFS_ASSERT_ALWAYS(a_free_count_range, free_count_ff <= CNT_W'(CAPACITY),
      "free slot count above capacity")
   `MFS_ASSERT_ALWAYS(a_value_zero,
      !rsp_valid_ff || rsp_status_ff == ST_POPPED || rsp_value_ff == '0,
      "nonzero value on a result that is not a pop")
   `MFS_ASSERT_NEXT(a_busy_after_accept, accept, state_ff == S_LOOKUP,
      "accepted item did not start a lookup")
   `MFS_ASSERT_ALWAYS(a_top_level_range, top_level_ff <= CNT_W'(CAPACITY),
      "top level above capacity")
endmodule

/* bench/tb.sv */
// Self-checking bench for max_frequency_stack: directed and random push/pop items
// checked against an in-bench frequency-stack predictor.
// Depends on mfs_pkg, mfs_if and the max_frequency_stack RTL.
`timescale 1ns / 1ps

module tb;
   import mfs_pkg::*;

   localparam int ITEM_COUNT  = 1000;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 20;

   // Frequency-stack predictor plus the queue of expected results.
   class freq_stack_sb;
      logic [DATA_W-1:0] slot_value[CAPACITY];
      int                slot_below[CAPACITY];
      int                level_head[CAPACITY];
      int                free_stack[CAPACITY];
      int                free_left;
      logic [DATA_W-1:0] tag_value[CAPACITY];
      int                tag_count[CAPACITY];
      int                high_level;
      logic [DATA_W-1:0] want_value[$];
      status_type        want_status[$];
      int                errors;
      int                status_seen[4];
      int                deepest;

      function new();
         errors = 0;
         deepest = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         for (int i = 0; i < CAPACITY; i++) begin
            level_head[i] = 0;
            free_stack[i] = i;
            tag_count[i]  = 0;
         end
         free_left  = CAPACITY;
         high_level = 0;
      endfunction

      function int pending();
         return want_status.size();
      endfunction

      function status_type push_value(logic [DATA_W-1:0] v);
         int t;
         int slot;
         int lvl;
         t = CAPACITY;
         for (int i = CAPACITY - 1; i >= 0; i--)
            if (tag_count[i] != 0 && tag_value[i] == v) t = i;
         if (free_left == 0) return ST_FULL;
         if (t == CAPACITY) begin
            for (int i = CAPACITY - 1; i >= 0; i--)
               if (tag_count[i] == 0) t = i;
            if (t == CAPACITY) return ST_FULL;
            tag_value[t] = v;
            tag_count[t] = 0;
         end
         if (tag_count[t] >= CAPACITY) return ST_FULL;
         tag_count[t]++;
         lvl = tag_count[t];
         free_left--;
         slot = free_stack[free_left];
         slot_value[slot] = v;
         slot_below[slot] = (level_head[lvl-1] == 0) ? slot : level_head[lvl-1] - 1;
         level_head[lvl-1] = slot + 1;
         if (lvl > high_level) high_level = lvl;
         if (lvl > deepest) deepest = lvl;
         return ST_PUSHED;
      endfunction

      function status_type pop_value(output logic [DATA_W-1:0] v);
         int slot;
         v = '0;
         if (high_level == 0) return ST_EMPTY;
         slot = level_head[high_level-1] - 1;
         v = slot_value[slot];
         if (slot_below[slot] == slot) begin
            level_head[high_level-1] = 0;
            high_level--;
         end else begin
            level_head[high_level-1] = slot_below[slot] + 1;
         end
         free_stack[free_left] = slot;
         free_left++;
         for (int i = 0; i < CAPACITY; i++)
            if (tag_count[i] != 0 && tag_value[i] == v) begin
               tag_count[i]--;
               break;
            end
         return ST_POPPED;
      endfunction

      function void note(logic f, logic [DATA_W-1:0] v);
         status_type st;
         logic [DATA_W-1:0] out;
         out = '0;
         if (f == FUNC_PUSH) st = push_value(v);
         else st = pop_value(out);
         want_value.insert(want_value.size(), out);
         want_status.insert(want_status.size(), st);
      endfunction

      function void check(logic [DATA_W-1:0] pv, logic [1:0] st);
         logic [DATA_W-1:0] ev;
         status_type es;
         if (want_status.size() == 0) begin
            $display("%0t: unexpected result value=%h status=%0d", $time, pv, st);
            errors++;
            return;
         end
         ev = want_value.pop_front();
         es = want_status.pop_front();
         status_seen[es]++;
         if (st !== es) begin
            $display("%0t: status mismatch expected %0d actual %0d", $time, es, st);
            errors++;
         end
         if (pv !== ev) begin
            $display("%0t: popped_value mismatch expected %h actual %h", $time, ev, pv);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   mfs_req_if req_chan();
   mfs_rsp_if rsp_chan();

   max_frequency_stack u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   freq_stack_sb sb = new();
   int send_idle_pct;
   int recv_idle_pct;
   logic hold_go;
   int hold_left;
   int cycles = 0;
   logic [DATA_W-1:0] value_pool[8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                                       32'h5, 32'h1234_5678, 32'hdead_beef, 32'h1};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.func <= FUNC_PUSH;
      req_chan.push_value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // receiver: random stalls, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_go && hold_left == 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= 300;
      end else if (hold_left > 1) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         if (hold_left == 1) hold_left <= -1;
      end
   end

   // check results first, then note the item accepted at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check(rsp_chan.popped_value, rsp_chan.status);
         if (req_chan.valid && req_chan.ready)
            sb.note(req_chan.func, req_chan.push_value);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_item(input logic f, input logic [DATA_W-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= f;
      req_chan.push_value <= v;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic drain_wait();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic pick_value(output logic [DATA_W-1:0] v);
      if ($urandom_range(3) != 0) v = value_pool[$urandom_range(7)];
      else v = $urandom;
   endtask

   initial begin
      int push_pct;
      logic [DATA_W-1:0] v;
      hold_go = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // directed: pop on empty, extreme values, rising frequency, drain past empty
      send_item(FUNC_POP, 32'h0);
      send_item(FUNC_PUSH, 32'h8000_0000);
      send_item(FUNC_PUSH, 32'h7fff_ffff);
      send_item(FUNC_PUSH, 32'h0);
      send_item(FUNC_PUSH, 32'hffff_ffff);
      repeat (3) send_item(FUNC_PUSH, 32'h5);
      send_item(FUNC_PUSH, 32'h7fff_ffff);
      repeat (10) send_item(FUNC_POP, 32'hffff_ffff);
      drain_wait();
      // fill to capacity, then refuse one
      for (int i = 0; i < CAPACITY; i++) send_item(FUNC_PUSH, value_pool[i % 3]);
      send_item(FUNC_PUSH, 32'h0bad_cafe);
      drain_wait();
      repeat (CAPACITY + 1) send_item(FUNC_POP, '0);
      drain_wait();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 45 : 0;
         recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 10 : 0;
         if (phase == 0) hold_go <= 1'b1;
         for (int n = 0; n < ITEM_COUNT / 3; n++) begin
            if (n % 50 == 0) push_pct = (n / 50 % 4 == 0) ? 100 : (n / 50 % 4 == 1) ? 15
                                      : (n / 50 % 4 == 2) ? 85 : 50;
            if (n == 10) hold_go <= 1'b0;
            pick_value(v);
            send_item(($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP, v);
         end
         drain_wait();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Covered %0d pushes, %0d pops, %0d empty pops, %0d refused pushes",
               sb.status_seen[ST_PUSHED], sb.status_seen[ST_POPPED],
               sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL]);
      $display("Deepest frequency level reached: %0d", sb.deepest);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
